>>> rtl/ukt_pkg.sv
`default_nettype none

package ukt_pkg;

    localparam int UKT_ENTRIES = 16;
    localparam int CMD_W       = 2;
    localparam int KEY_W       = 32;
    localparam int STATUS_W    = 3;

    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_ERASE  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_SEARCH = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_EXISTS    = 3'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd4;

endpackage

`default_nettype wire

>>> rtl/ukt_if.sv
`default_nettype none

interface ukt_cmd_if;
    import ukt_pkg::*;

    logic             valid;
    logic             ready;
    logic [CMD_W-1:0] command;
    logic [KEY_W-1:0] key;
    logic [KEY_W-1:0] parent_key;
    logic [KEY_W-1:0] info_value;

    modport source (output valid, command, key, parent_key, info_value, input ready);
    modport sink   (input valid, command, key, parent_key, info_value, output ready);
endinterface

interface ukt_rsp_if;
    import ukt_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [KEY_W-1:0]    found_parent;
    logic [KEY_W-1:0]    found_info;

    modport source (output valid, status, found_parent, found_info, input ready);
    modport sink   (input valid, status, found_parent, found_info, output ready);
endinterface

`default_nettype wire

>>> rtl/ukt_ram.sv
`default_nettype none

module ukt_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        // hold the last read word while no read is issued
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

>>> rtl/unique_key_table.sv
`default_nettype none

// Bounded key/value table with unique keys. Each command item (insert, erase,
// search) is held in an input register, then checked against every stored key
// at once; the table update and the result status are registered when the item
// leaves the input register, together with the read of the parent/info RAM for
// a search hit. One command is taken every cycle while ready is high; the rate
// is set by the combinational parallel key compare over all ENTRIES slots plus
// the one-port-each write/read of the data RAM. Ready drops only while a result
// waits at the output and the input register is also full. Insert uses the
// lowest free slot; found_parent and found_info read zero for every result
// except a successful search.
module unique_key_table #(
    parameter int ENTRIES = ukt_pkg::UKT_ENTRIES
) (
    input wire logic i_clk,
    input wire logic i_rst_n,
    ukt_cmd_if.sink  i_cmd,
    ukt_rsp_if.source o_rsp
);
    import ukt_pkg::*;

    localparam int IDX_W  = $clog2(ENTRIES);
    localparam int DATA_W = 2 * KEY_W;

    // input register
    logic             r_a_valid;
    logic [CMD_W-1:0] r_a_cmd;
    logic [KEY_W-1:0] r_a_key;
    logic [KEY_W-1:0] r_a_parent;
    logic [KEY_W-1:0] r_a_info;

    // result register
    logic                r_b_valid;
    logic [STATUS_W-1:0] r_b_status;
    logic                r_b_hit;

    // table
    logic [ENTRIES-1:0] r_valid;
    logic [ENTRIES-1:0] n_valid;
    logic [KEY_W-1:0]   r_keys [ENTRIES];

    logic                adv;
    logic                step;
    logic [ENTRIES-1:0]  match;
    logic                any_hit;
    logic [IDX_W-1:0]    hit_idx;
    logic [IDX_W-1:0]    free_idx;
    logic                tbl_full;
    logic                tbl_empty;
    logic                ins_ok;
    logic                erase_ok;
    logic                search_ok;
    logic [STATUS_W-1:0] n_status;
    logic [DATA_W-1:0]   rd_data;

    assign adv         = !r_b_valid || o_rsp.ready;
    assign step        = adv && r_a_valid;
    assign i_cmd.ready = adv || !r_a_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (i_cmd.ready) begin
            r_a_valid <= i_cmd.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.valid && i_cmd.ready) begin
            r_a_cmd    <= i_cmd.command;
            r_a_key    <= i_cmd.key;
            r_a_parent <= i_cmd.parent_key;
            r_a_info   <= i_cmd.info_value;
        end
    end

    // parallel compare, lowest-index hit and lowest free slot
    always_comb begin
        hit_idx  = '0;
        free_idx = '0;
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            match[i] = r_valid[i] && (r_keys[i] == r_a_key);
            if (match[i]) begin
                hit_idx = IDX_W'(i);
            end
            if (!r_valid[i]) begin
                free_idx = IDX_W'(i);
            end
        end
    end

    assign any_hit   = |match;
    assign tbl_full  = &r_valid;
    assign tbl_empty = ~|r_valid;

    always_comb begin
        n_status  = ST_OK;
        ins_ok    = 1'b0;
        erase_ok  = 1'b0;
        search_ok = 1'b0;
        case (r_a_cmd)
            CMD_INSERT: begin
                if (any_hit) begin
                    n_status = ST_EXISTS;
                end else if (tbl_full) begin
                    n_status = ST_FULL;
                end else begin
                    ins_ok = 1'b1;
                end
            end
            CMD_ERASE, CMD_SEARCH: begin
                if (tbl_empty) begin
                    n_status = ST_EMPTY;
                end else if (!any_hit) begin
                    n_status = ST_NOT_FOUND;
                end else if (r_a_cmd == CMD_ERASE) begin
                    erase_ok = 1'b1;
                end else begin
                    search_ok = 1'b1;
                end
            end
            default: begin
                n_status = ST_OK;
            end
        endcase
    end

    always_comb begin
        n_valid = r_valid;
        if (ins_ok) begin
            n_valid[free_idx] = 1'b1;
        end
        if (erase_ok) begin
            n_valid[hit_idx] = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (step) begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step && ins_ok) begin
            r_keys[free_idx] <= r_a_key;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (adv) begin
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_b_status <= n_status;
            r_b_hit    <= search_ok;
        end
    end

    ukt_ram #(
        .WIDTH (DATA_W),
        .DEPTH (ENTRIES)
    ) u_data_ram (
        .i_clk   (i_clk),
        .i_we    (step && ins_ok),
        .i_waddr (free_idx),
        .i_wdata ({r_a_parent, r_a_info}),
        .i_re    (step && search_ok),
        .i_raddr (hit_idx),
        .o_rdata (rd_data)
    );

    assign o_rsp.valid        = r_b_valid;
    assign o_rsp.status       = r_b_status;
    assign o_rsp.found_parent = r_b_hit ? rd_data[DATA_W-1:KEY_W] : '0;
    assign o_rsp.found_info   = r_b_hit ? rd_data[KEY_W-1:0] : '0;

    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (step && ins_ok) |=> ($countones(r_valid) == $past($countones(r_valid)) + 1))
        else $error("successful insert did not add exactly one entry");

    a_empty_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_b_valid && r_b_status == ST_EMPTY) |-> (r_valid == '0))
        else $error("empty status reported while entries are valid");

    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_b_valid && r_b_status == ST_FULL) |-> (&r_valid))
        else $error("full status reported while a slot is free");

    a_hit_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_b_valid && r_b_hit) |-> (r_b_status == ST_OK))
        else $error("search data returned with a failing status");

endmodule

`default_nettype wire

>>> sim/tb.sv
`timescale 1ns / 1ps

module tb;
    import ukt_pkg::*;

    localparam int TABLE_SLOTS = UKT_ENTRIES;
    localparam int RAND_ITEMS  = 1000;
    localparam int POOL_KEYS   = 24;
    localparam int CYCLE_LIMIT = 400000;
    localparam int SETTLE      = 8;
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam logic [KEY_W-1:0] ONES       = '1;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [KEY_W-1:0]    parent;
        logic [KEY_W-1:0]    info;
    } lookup_result_t;

    typedef struct {
        logic [CMD_W-1:0] cmd;
        logic [KEY_W-1:0] key;
        logic [KEY_W-1:0] parent;
        logic [KEY_W-1:0] info;
        bit               fixed;
        lookup_result_t   want;
    } table_cmd_t;

    logic clk;
    logic rst_n;

    ukt_cmd_if cmd_if();
    ukt_rsp_if rsp_if();

    unique_key_table u_top (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_cmd   (cmd_if),
        .o_rsp   (rsp_if)
    );

    // mirror of the table contents
    bit               slot_used   [TABLE_SLOTS];
    logic [KEY_W-1:0] slot_key    [TABLE_SLOTS];
    logic [KEY_W-1:0] slot_parent [TABLE_SLOTS];
    logic [KEY_W-1:0] slot_info   [TABLE_SLOTS];

    lookup_result_t   pending_results[$];
    table_cmd_t       directed_cmds[$];
    logic [KEY_W-1:0] key_pool[POOL_KEYS];

    // typed expectation riding along with the item on the bus
    bit             item_fixed;
    lookup_result_t item_want;

    int errors;
    int cycle_cnt;
    int cmds_taken;
    int status_count[5];
    bit long_hold_req;
    bit recv_calm;
    int send_calm_left;

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    always @(posedge clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_cnt, pending_results.size());
            $display("FAIL");
            $finish;
        end
    end

    function automatic lookup_result_t apply_table_cmd(logic [CMD_W-1:0] cmd,
                                                       logic [KEY_W-1:0] key,
                                                       logic [KEY_W-1:0] parent,
                                                       logic [KEY_W-1:0] info);
        lookup_result_t res;
        int             hit;
        int             free_slot;
        bit             any_used;
        int             i;
        res       = '0;
        res.status = ST_OK;
        hit       = -1;
        free_slot = -1;
        any_used  = 1'b0;
        for (i = 0; i < TABLE_SLOTS; i++) begin
            if (slot_used[i]) begin
                any_used = 1'b1;
                if (hit < 0 && slot_key[i] == key)
                    hit = i;
            end else if (free_slot < 0) begin
                free_slot = i;
            end
        end
        case (cmd)
            CMD_INSERT: begin
                if (hit >= 0) begin
                    res.status = ST_EXISTS;
                end else if (free_slot < 0) begin
                    res.status = ST_FULL;
                end else begin
                    slot_used[free_slot]   = 1'b1;
                    slot_key[free_slot]    = key;
                    slot_parent[free_slot] = parent;
                    slot_info[free_slot]   = info;
                end
            end
            CMD_ERASE, CMD_SEARCH: begin
                if (!any_used) begin
                    res.status = ST_EMPTY;
                end else if (hit < 0) begin
                    res.status = ST_NOT_FOUND;
                end else if (cmd == CMD_ERASE) begin
                    slot_used[hit] = 1'b0;
                end else begin
                    res.parent = slot_parent[hit];
                    res.info   = slot_info[hit];
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    task automatic report_mismatch(string what, logic [KEY_W-1:0] want,
                                   logic [KEY_W-1:0] got);
        $display("mismatch at cycle %0d: %s expected %h got %h", cycle_cnt, what, want, got);
        errors++;
    endtask

    always @(posedge clk) begin
        lookup_result_t want;
        if (rst_n) begin
            if (cmd_if.valid && cmd_if.ready) begin
                want = apply_table_cmd(cmd_if.command, cmd_if.key,
                                       cmd_if.parent_key, cmd_if.info_value);
                if (item_fixed)
                    want = item_want;
                pending_results.push_back(want);
                cmds_taken++;
            end
            if (rsp_if.valid && rsp_if.ready) begin
                if (pending_results.size() == 0) begin
                    report_mismatch("result with nothing outstanding, status", '0,
                                    rsp_if.status);
                end else begin
                    want = pending_results.pop_front();
                    if (rsp_if.status !== want.status)
                        report_mismatch("status", want.status, rsp_if.status);
                    if (rsp_if.found_parent !== want.parent)
                        report_mismatch("found_parent", want.parent, rsp_if.found_parent);
                    if (rsp_if.found_info !== want.info)
                        report_mismatch("found_info", want.info, rsp_if.found_info);
                end
                if (rsp_if.status <= ST_FULL)
                    status_count[rsp_if.status]++;
            end
        end
    end

    // result side: random back-pressure plus one long hold on request
    initial begin
        int stall;
        int pick;
        rsp_if.ready = 1'b0;
        stall = 0;
        wait (rst_n);
        forever begin
            @(posedge clk);
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                stall = 80;
            end else if (stall == 0 && !recv_calm) begin
                pick = $urandom_range(0, 99);
                if (pick >= 95)
                    stall = $urandom_range(8, 30);
                else if (pick >= 70)
                    stall = $urandom_range(1, 3);
            end
            if (stall > 0) begin
                rsp_if.ready <= 1'b0;
                stall--;
            end else begin
                rsp_if.ready <= 1'b1;
            end
        end
    end

    function automatic table_cmd_t mk_cmd(logic [CMD_W-1:0] cmd, logic [KEY_W-1:0] key,
                                          logic [KEY_W-1:0] parent,
                                          logic [KEY_W-1:0] info, bit fixed,
                                          logic [STATUS_W-1:0] status,
                                          logic [KEY_W-1:0] found_parent,
                                          logic [KEY_W-1:0] found_info);
        table_cmd_t c;
        c.cmd         = cmd;
        c.key         = key;
        c.parent      = parent;
        c.info        = info;
        c.fixed       = fixed;
        c.want.status = status;
        c.want.parent = found_parent;
        c.want.info   = found_info;
        return c;
    endfunction

    task automatic send_cmd(input table_cmd_t c);
        int gap;
        int pick;
        gap = 0;
        if (send_calm_left > 0) begin
            send_calm_left--;
        end else begin
            pick = $urandom_range(0, 99);
            if (pick >= 90)
                gap = $urandom_range(6, 25);
            else if (pick >= 55)
                gap = $urandom_range(1, 3);
        end
        repeat (gap) begin
            cmd_if.valid      <= 1'b0;
            cmd_if.command    <= CMD_W'($urandom);
            cmd_if.key        <= $urandom;
            cmd_if.parent_key <= $urandom;
            cmd_if.info_value <= $urandom;
            @(posedge clk);
        end
        cmd_if.valid      <= 1'b1;
        cmd_if.command    <= c.cmd;
        cmd_if.key        <= c.key;
        cmd_if.parent_key <= c.parent;
        cmd_if.info_value <= c.info;
        item_fixed        <= c.fixed;
        item_want         <= c.want;
        do @(posedge clk); while (!cmd_if.ready);
    endtask

    task automatic drain_results();
        cmd_if.valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    initial begin
        table_cmd_t c;
        int         i;
        int         n;
        int         pick;
        bit         insert_heavy;

        rst_n             = 1'b0;
        cmd_if.valid      = 1'b0;
        cmd_if.command    = CMD_INSERT;
        cmd_if.key        = '0;
        cmd_if.parent_key = '0;
        cmd_if.info_value = '0;
        item_fixed        = 1'b0;
        item_want         = '0;

        key_pool[0] = '0;
        key_pool[1] = ONES;
        for (i = 2; i < POOL_KEYS; i++)
            key_pool[i] = $urandom;

        directed_cmds.push_back(mk_cmd(CMD_SEARCH, '0, '0, '0, 1'b1, ST_EMPTY, '0, '0));
        directed_cmds.push_back(mk_cmd(CMD_ERASE, ONES, ONES, ONES, 1'b1, ST_EMPTY, '0, '0));
        directed_cmds.push_back(mk_cmd(CMD_INSERT, '0, '0, '0, 1'b1, ST_OK, '0, '0));
        directed_cmds.push_back(mk_cmd(CMD_INSERT, ONES, ONES, ONES, 1'b1, ST_OK, '0, '0));
        directed_cmds.push_back(mk_cmd(CMD_INSERT, '0, 32'h1234_5678, 32'h9abc_def0, 1'b1,
                                       ST_EXISTS, '0, '0));
        directed_cmds.push_back(mk_cmd(CMD_SEARCH, '0, ONES, ONES, 1'b1, ST_OK, '0, '0));
        directed_cmds.push_back(mk_cmd(CMD_SEARCH, ONES, '0, '0, 1'b1, ST_OK, ONES, ONES));
        directed_cmds.push_back(mk_cmd(CMD_SEARCH, 32'h8000_0001, '0, '0, 1'b1,
                                       ST_NOT_FOUND, '0, '0));
        directed_cmds.push_back(mk_cmd(CMD_ERASE, 32'h7fff_fffe, '0, '0, 1'b1,
                                       ST_NOT_FOUND, '0, '0));
        // fill the remaining slots
        for (i = 0; i < TABLE_SLOTS - 2; i++)
            directed_cmds.push_back(mk_cmd(CMD_INSERT, 32'hc0de_0000 + i, $urandom, $urandom,
                                           1'b1, ST_OK, '0, '0));
        directed_cmds.push_back(mk_cmd(CMD_INSERT, 32'hdead_beef, '0, '0, 1'b1,
                                       ST_FULL, '0, '0));
        // a present key reports exists even on a full table
        directed_cmds.push_back(mk_cmd(CMD_INSERT, ONES, '0, '0, 1'b1, ST_EXISTS, '0, '0));
        directed_cmds.push_back(mk_cmd(CMD_UNUSED, 32'h5555_5555, ONES, ONES, 1'b1,
                                       ST_OK, '0, '0));
        directed_cmds.push_back(mk_cmd(CMD_ERASE, '0, '0, '0, 1'b1, ST_OK, '0, '0));
        directed_cmds.push_back(mk_cmd(CMD_INSERT, 32'hdead_beef, 32'h0bad_f00d,
                                       32'hfeed_face, 1'b1, ST_OK, '0, '0));
        directed_cmds.push_back(mk_cmd(CMD_SEARCH, 32'hdead_beef, '0, '0, 1'b0,
                                       ST_OK, '0, '0));

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_cmds[i])
            send_cmd(directed_cmds[i]);
        drain_results();

        for (n = 0; n < RAND_ITEMS; n++) begin
            if (n == RAND_ITEMS / 2)
                drain_results();
            if (n == 300)
                send_calm_left = 60;
            recv_calm = (n >= 300 && n < 360);
            // long hold at the output while items keep coming
            if (n == 650) begin
                long_hold_req  = 1'b1;
                send_calm_left = 60;
            end
            insert_heavy = ((n / 70) % 2) == 0;
            pick = $urandom_range(0, 99);
            if (insert_heavy)
                c.cmd = (pick < 55) ? CMD_INSERT : (pick < 70) ? CMD_ERASE :
                        (pick < 95) ? CMD_SEARCH : CMD_UNUSED;
            else
                c.cmd = (pick < 15) ? CMD_INSERT : (pick < 60) ? CMD_ERASE :
                        (pick < 95) ? CMD_SEARCH : CMD_UNUSED;
            c.key = key_pool[$urandom_range(0, POOL_KEYS - 1)];
            if (c.cmd != CMD_INSERT && $urandom_range(0, 9) == 0)
                c.key = $urandom;
            c.parent = $urandom;
            c.info   = $urandom;
            c.fixed  = 1'b0;
            c.want   = '0;
            send_cmd(c);
        end

        drain_results();
        repeat (SETTLE) @(posedge clk);

        $display("covered %0d commands; results ok %0d, exists %0d, not found %0d,",
                 cmds_taken, status_count[ST_OK], status_count[ST_EXISTS],
                 status_count[ST_NOT_FOUND]);
        $display("empty %0d, full %0d; field mismatches: %0d",
                 status_count[ST_EMPTY], status_count[ST_FULL], errors);
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
